[rtl/core/rbx_pkg.sv]
package rbx_pkg;

	// number format
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// divider sizing: the dividend is the distance magnitude shifted left by the fraction
	localparam int DVD_W = COORD_WIDTH + FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W + 1);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [COORD_WIDTH-1:0]        mag_t;
	typedef logic [DVD_W-1:0]              dvd_t;
	typedef logic [CNT_W-1:0]              cnt_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam cnt_t   DIV_STEPS = CNT_W'(DVD_W);

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;   // capture the request fields
		logic start_div; // load the divider
		logic sel_lo;    // divider numerator uses the lower bound
		logic div_step;  // one restoring division step
		logic cap_hi;    // keep the upper-bound quotient
		logic fold;      // fold the larger quotient into the running minimum
		logic emit;      // write the result register and restart
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic dir_zero;
		logic div_done;
		logic last;
		logic out_free;
	} stat_t;

endpackage

[rtl/core/ray_box_exit_distance.sv]
// ray exit distance from an axis-aligned box, one dimension per request
// two serial restoring divisions of COORD_WIDTH+FRAC_BITS steps each (48 at Q16.16) in one
//   shared divider, plus sequencing; a zero direction skips both divisions and is not folded
// throughput: one request at a time; a new request is taken only once the previous dimension
//   is done and, after a last one, its result is written, which waits while a result is pending
// reset: asynchronous, clears controller, divider count, running minimum and result valid
module ray_box_exit_distance (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rbx_pkg::coord_t lower_bound,
	input  rbx_pkg::coord_t upper_bound,
	input  rbx_pkg::coord_t origin_coord,
	input  rbx_pkg::coord_t direction_coord,
	input  logic            last_dim,
	output logic            out_valid,
	input  logic            out_stall,
	output rbx_pkg::coord_t exit_distance,
	output logic            unbounded
);
	import rbx_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencing
	rbx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// divider, minimum tracking and result register
	rbx_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.lower_bound     (lower_bound),
		.upper_bound     (upper_bound),
		.origin_coord    (origin_coord),
		.direction_coord (direction_coord),
		.last_dim        (last_dim),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.exit_distance   (exit_distance),
		.unbounded       (unbounded)
	);

endmodule

[rtl/core/rbx_datapath.sv]
module rbx_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rbx_pkg::coord_t       lower_bound,
	input  rbx_pkg::coord_t       upper_bound,
	input  rbx_pkg::coord_t       origin_coord,
	input  rbx_pkg::coord_t       direction_coord,
	input  logic                  last_dim,
	input  rbx_pkg::cmd_t         cmd,
	output rbx_pkg::stat_t        stat,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rbx_pkg::coord_t       exit_distance,
	output logic                  unbounded
);
	import rbx_pkg::*;

	coord_t lo_q, hi_q, org_q, dir_q;
	logic   last_q;

	coord_t bound;
	logic signed [COORD_WIDTH:0] diff, diff_neg;
	mag_t   num_mag, den_mag, dir_neg;

	mag_t   den_q;
	mag_t   rem_q;
	dvd_t   dvd_q, quo_q;
	cnt_t   cnt_q;
	logic   neg_q;

	logic [COORD_WIDTH:0] trial, trial_sub;
	logic   ge;

	logic   over;
	mag_t   quo_neg;
	coord_t quot_sat;

	coord_t qh_q, wide_q;
	coord_t min_q;
	logic   any_q;

	logic   out_valid_q;
	coord_t out_dist_q;
	logic   out_unb_q;

	// request field capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			lo_q   <= lower_bound;
			hi_q   <= upper_bound;
			org_q  <= origin_coord;
			dir_q  <= direction_coord;
			last_q <= last_dim;
		end
	end

	// numerator and divisor magnitudes
	assign bound    = cmd.sel_lo ? lo_q : hi_q;
	assign diff     = {bound[COORD_WIDTH-1], bound} - {org_q[COORD_WIDTH-1], org_q};
	assign diff_neg = -diff;
	assign num_mag  = diff[COORD_WIDTH] ? diff_neg[COORD_WIDTH-1:0] : diff[COORD_WIDTH-1:0];
	assign dir_neg  = mag_t'(-dir_q);
	assign den_mag  = dir_q[COORD_WIDTH-1] ? dir_neg : mag_t'(dir_q);

	// restoring division step
	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_div) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			dvd_q <= dvd_t'(num_mag) << FRAC_BITS;
			den_q <= den_mag;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= diff[COORD_WIDTH] ^ dir_q[COORD_WIDTH-1];
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? trial_sub[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	// sign and saturation of the finished quotient
	assign over     = |quo_q[DVD_W-1:COORD_WIDTH-1];
	assign quo_neg  = -quo_q[COORD_WIDTH-1:0];
	assign quot_sat = neg_q ? (over ? COORD_MIN : coord_t'(quo_neg))
	                        : (over ? COORD_MAX : coord_t'(quo_q[COORD_WIDTH-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.cap_hi) begin
			qh_q <= quot_sat;
		end
	end

	// larger of the two slab quotients
	assign wide_q = (qh_q > quot_sat) ? qh_q : quot_sat;

	// running minimum over the dimensions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= COORD_MAX;
			any_q <= 1'b0;
		end else if (cmd.emit) begin
			min_q <= COORD_MAX;
			any_q <= 1'b0;
		end else if (cmd.fold) begin
			if (wide_q < min_q) begin
				min_q <= wide_q;
			end
			any_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_dist_q <= min_q;
			out_unb_q  <= !any_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign exit_distance = out_dist_q;
	assign unbounded     = out_unb_q;

	assign stat.dir_zero = (dir_q == '0);
	assign stat.div_done = (cnt_q == DIV_STEPS);
	assign stat.last     = last_q;
	assign stat.out_free = !out_valid_q;

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q)
		else $error("result written while previous result pending");

	// divider never steps past its last quotient bit
	a_no_overstep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (cnt_q != DIV_STEPS))
		else $error("divider stepped past completion");

	// state restarts after a result
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (min_q == COORD_MAX) && !any_q)
		else $error("running state not cleared after result");

endmodule

[rtl/core/rbx_ctrl.sv]
module rbx_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rbx_pkg::stat_t stat,
	output rbx_pkg::cmd_t  cmd
);
	import rbx_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_START  = 6'b000010,
		ST_DIV_HI = 6'b000100,
		ST_DIV_LO = 6'b001000,
		ST_FOLD   = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				if (stat.dir_zero) begin
					state_d = stat.last ? ST_EMIT : ST_IDLE;
				end else begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV_HI;
				end
			end
			ST_DIV_HI: begin
				if (stat.div_done) begin
					cmd.cap_hi    = 1'b1;
					cmd.start_div = 1'b1;
					cmd.sel_lo    = 1'b1;
					state_d       = ST_DIV_LO;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DIV_LO: begin
				if (stat.div_done) begin
					state_d = ST_FOLD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = stat.last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// an accepted request always goes to the direction check
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_START)
		else $error("accepted request did not start");

	// results only come from a last dimension
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.last)
		else $error("result emitted for a non-final dimension");

	// the lower-bound division starts only after the upper one finished
	a_lo_after_hi: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_lo |-> (state_q == ST_DIV_HI) && stat.div_done)
		else $error("lower-bound division started early");

endmodule
